// ----- hdl/qpd_pkg.sv -----
// ----------------------------------------------------------------------------
// qpd_pkg: shared definitions for the quoted-printable decoder
// Character codes and the small character-class helpers used by the decoder.
// ----------------------------------------------------------------------------
package qpd_pkg;

  localparam logic [7:0] ESC_CHAR        = 8'h3D;  // '='
  localparam logic [7:0] UNDERSCORE_CHAR = 8'h5F;  // '_'
  localparam logic [7:0] SPACE_CHAR      = 8'h20;
  localparam logic [7:0] BAD_BYTE        = 8'hBF;
  localparam logic [7:0] NUL_CHAR        = 8'h00;

  // Hex digit lookup result: nibble plus an invalid mark
  typedef struct packed {
    logic       invalid;
    logic [3:0] nibble;
  } hex_digit_t;

  // Space, tab, line feed, vertical tab, form feed, carriage return
  function automatic logic is_white(input logic [7:0] c);
    logic white;
    case (c) inside
      8'h20, [8'h09:8'h0D]: white = 1'b1;
      default:              white = 1'b0;
    endcase
    return white;
  endfunction

  // Decode one hex digit in either case
  function automatic hex_digit_t hex_of(input logic [7:0] c);
    hex_digit_t d;
    d.invalid = 1'b0;
    d.nibble  = 4'h0;
    case (c) inside
      [8'h30:8'h39]: d.nibble = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: d.nibble = c[3:0] + 4'd9;
      default:       d.invalid = 1'b1;
    endcase
    return d;
  endfunction

endpackage

// ----- hdl/qpd_if.sv -----
// ----------------------------------------------------------------------------
// qpd_if: channel interfaces of the quoted-printable decoder
// Valid/ready channels for encoded bytes, decoded bytes and the mode register.
// ----------------------------------------------------------------------------

// Encoded byte channel
interface qpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// Decoded byte channel
interface qpd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       bad_escape;

  modport source (output valid, output out_byte, output bad_escape, input ready);
  modport sink   (input valid, input out_byte, input bad_escape, output ready);
endinterface

// Mode register write channel
interface qpd_cfg_if;
  logic valid;
  logic ready;
  logic space_mode;

  modport source (output valid, output space_mode, input ready);
  modport sink   (input valid, input space_mode, output ready);
endinterface

// ----- hdl/quoted_printable_decoder.sv -----
// ----------------------------------------------------------------------------
// quoted_printable_decoder: streaming quoted-printable decoder
// One encoded byte per transaction in, zero or one decoded byte out.
// ----------------------------------------------------------------------------
// Usage:
//   src  - encoded bytes (in_byte), one per transaction.
//   dst  - decoded bytes (out_byte) with bad_escape set when an escape pair
//          was not two hex digits; out_byte is then 0xBF.
//   cfg  - write of space_mode; always ready, write only while idle.
// An '=' opens an escape and the next two bytes form the digit pair; those
// three inputs give one output. In space mode whitespace is dropped and '_'
// outside an escape becomes a space; in plain mode a zero byte outside an
// escape is dropped.
// A result appears on dst in the cycle after the transaction that completes
// it. Throughput: one byte per cycle while dst takes results, set by the
// single output register, refilled in the same cycle it is drained.
// Stall: while dst holds a result that is not taken, src.ready is low.
// Reset (rst, synchronous): clears the escape state, empties the output
// register and returns to plain mode.
// ----------------------------------------------------------------------------
module quoted_printable_decoder (
  input logic      clk,
  input logic      rst,
  qpd_in_if.sink   src,
  qpd_out_if.source dst,
  qpd_cfg_if.sink  cfg
);
  import qpd_pkg::*;

  logic       space_mode;
  logic       escape_pending;
  logic       digits_held;
  logic [7:0] first_digit;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       bad_escape;

  logic       escape_pending_next;
  logic       digits_held_next;
  logic [7:0] first_digit_next;
  logic       emit;
  logic [7:0] res_byte;
  logic       res_bad;
  logic       in_take;
  hex_digit_t hi_digit;
  hex_digit_t lo_digit;

  // Accept while the output register is empty or being drained
  assign src.ready = !out_valid || dst.ready;
  assign in_take   = src.valid && src.ready;
  assign cfg.ready = 1'b1;

  assign dst.valid      = out_valid;
  assign dst.out_byte   = out_byte;
  assign dst.bad_escape = bad_escape;

  assign hi_digit = hex_of(first_digit);
  assign lo_digit = hex_of(src.in_byte);

  // Decode one byte against the escape state
  always_comb begin
    escape_pending_next = escape_pending;
    digits_held_next    = digits_held;
    first_digit_next    = first_digit;
    emit                = 1'b0;
    res_byte            = src.in_byte;
    res_bad             = 1'b0;
    if (space_mode && is_white(src.in_byte)) begin
      emit = 1'b0;
    end else if (escape_pending) begin
      if (!digits_held) begin
        first_digit_next = src.in_byte;
        digits_held_next = 1'b1;
      end else begin
        escape_pending_next = 1'b0;
        digits_held_next    = 1'b0;
        first_digit_next    = NUL_CHAR;
        emit                = 1'b1;
        if (!hi_digit.invalid && !lo_digit.invalid) begin
          res_byte = {hi_digit.nibble, lo_digit.nibble};
        end else begin
          res_byte = BAD_BYTE;
          res_bad  = 1'b1;
        end
      end
    end else if (src.in_byte == ESC_CHAR) begin
      escape_pending_next = 1'b1;
      digits_held_next    = 1'b0;
    end else if (space_mode) begin
      emit     = 1'b1;
      res_byte = (src.in_byte == UNDERSCORE_CHAR) ? SPACE_CHAR : src.in_byte;
    end else begin
      emit = (src.in_byte != NUL_CHAR);
    end
  end

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      space_mode <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      space_mode <= cfg.space_mode;
    end
  end

  // Advance the escape state on each input transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
      digits_held    <= 1'b0;
      first_digit    <= NUL_CHAR;
    end else if (in_take) begin
      escape_pending <= escape_pending_next;
      digits_held    <= digits_held_next;
      first_digit    <= first_digit_next;
    end
  end

  // Load the output register, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_take && emit) begin
      out_valid <= 1'b1;
    end else if (dst.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && emit) begin
      out_byte   <= res_byte;
      bad_escape <= res_bad;
    end
  end

  // A held digit only exists inside an escape
  a_held_in_escape: assert property (@(posedge clk) disable iff (rst)
    digits_held |-> escape_pending)
    else $error("digit held outside an escape");

  // A flagged result always carries the replacement byte
  a_bad_byte: assert property (@(posedge clk) disable iff (rst)
    (out_valid && bad_escape) |-> (out_byte == BAD_BYTE))
    else $error("bad escape without replacement byte");

  // The second digit of a pair always yields a result
  a_pair_emits: assert property (@(posedge clk) disable iff (rst)
    (in_take && escape_pending && digits_held &&
     !(space_mode && is_white(src.in_byte))) |=> out_valid)
    else $error("escape pair completed without a result");

  // An '=' outside an escape opens one with no digit held
  a_escape_opens: assert property (@(posedge clk) disable iff (rst)
    (in_take && !escape_pending && src.in_byte == ESC_CHAR) |=>
    (escape_pending && !digits_held))
    else $error("escape did not open");

  // A stalled result blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !dst.ready) |-> !src.ready)
    else $error("input accepted while output stalled");

endmodule
